FILE: rtl/hfl_pkg.sv
`timescale 1ns / 1ps
package hfl_pkg;

    localparam int DEF_MAX_STATES = 4;
    localparam int DEF_MAX_GAP    = 255;

    localparam int PROB_W  = 16;
    localparam int PROD_W  = 32;
    localparam int MUL_W   = 64;
    localparam int SCALE_W = 34;
    localparam int NUM_W   = 48;
    localparam int QUOT_W  = 16;
    localparam int MANT_W  = 31;
    localparam int FRAC_W  = 16;
    localparam int LL_W    = 32;
    localparam int EXP_W   = 6;

    localparam logic [1:0] CMD_LOAD_TRANS = 2'd0;
    localparam logic [1:0] CMD_LOAD_INIT  = 2'd1;
    localparam logic [1:0] CMD_OBSERVE    = 2'd2;

    localparam logic [1:0] REG_NUM_STATES = 2'd0;
    localparam logic [1:0] REG_GAP_MODE   = 2'd1;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef struct packed {
        logic start;
        logic [NUM_W-1:0] num;
        logic [SCALE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

FILE: rtl/hfl_mul.sv
`timescale 1ns / 1ps
module hfl_mul
    import hfl_pkg::*;
(
    input  logic             i_clk,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    output logic [MUL_W-1:0] o_p
);

    logic [MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;

endmodule

FILE: rtl/hfl_div.sv
`timescale 1ns / 1ps
module hfl_div
    import hfl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic [SCALE_W-1:0] r_rem;
    logic [SCALE_W-1:0] r_den;
    logic [QUOT_W-1:0]  r_num;
    logic [QUOT_W-1:0]  r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [SCALE_W:0]   w_rem2;
    logic               w_ge;

    assign w_rem2 = {r_rem, r_num[QUOT_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= SCALE_W'(i_req.num[NUM_W-1:QUOT_W]);
            r_num <= i_req.num[QUOT_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? SCALE_W'(w_rem2 - {1'b0, r_den}) : w_rem2[SCALE_W-1:0];
            r_num <= {r_num[QUOT_W-2:0], 1'b0};
            r_q   <= {r_q[QUOT_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 1'b1;
                r_busy <= (r_cnt != CNT_W'(QUOT_W - 1));
                r_done <= (r_cnt == CNT_W'(QUOT_W - 1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: rtl/hmm_forward_loglik_unit.sv
`timescale 1ns / 1ps
// load items are written without leaving idle; an observation propagates the
// forward vector reps times over the n states in use, on one shared registered
// 32x32 multiplier, with a 16-step serial divider per state, a leading-one search
// and 16 squaring steps; one item at a time, the result register frees the input
// synchronous active-low reset clears forward vector, log-likelihood, flag and registers
module hmm_forward_loglik_unit
    import hfl_pkg::*;
#(
    parameter int MAX_STATES = DEF_MAX_STATES,
    parameter int MAX_GAP    = DEF_MAX_GAP
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,  // row_index, col_index, prob_value, time_gap,
                                         // emit_a, emit_b, emit_c, emit_d, zero pad
    input  logic [2:0]  i_s_axis_tuser,  // cmd, seq_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // log_likelihood
    output logic        o_m_axis_tuser,  // underflow_flag
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data
);

    localparam int IDX_W = (MAX_STATES > 2) ? $clog2(MAX_STATES) : 1;
    localparam int GAP_W = (MAX_GAP > 1) ? $clog2(MAX_GAP + 1) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PMUL   = 4'd1;
    localparam logic [3:0] S_PACC   = 4'd2;
    localparam logic [3:0] S_WMUL   = 4'd3;
    localparam logic [3:0] S_WACC   = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_NORM   = 4'd7;
    localparam logic [3:0] S_SMUL   = 4'd8;
    localparam logic [3:0] S_SSTEP  = 4'd9;
    localparam logic [3:0] S_LMUL   = 4'd10;
    localparam logic [3:0] S_LACC   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0] r_state;

    logic [PROB_W-1:0] r_trans [MAX_STATES][MAX_STATES];
    logic [PROB_W-1:0] r_init  [MAX_STATES];
    logic [PROB_W-1:0] r_fv    [MAX_STATES];
    logic [PROB_W-1:0] r_pred  [MAX_STATES];
    logic [PROB_W-1:0] r_nxt   [MAX_STATES];
    logic [PROB_W-1:0] r_emit  [MAX_STATES];
    logic [PROD_W-1:0] r_u     [MAX_STATES];

    logic [2:0]         r_num_states;
    logic               r_gap_mode;
    logic [IDX_W-1:0]   r_last;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_col;
    logic [GAP_W-1:0]   r_reps;
    logic [SCALE_W-1:0] r_acc;
    logic [SCALE_W-1:0] r_scale;
    logic [SCALE_W-1:0] r_norm;
    logic [EXP_W-1:0]   r_exp;
    logic [MANT_W-1:0]  r_m;
    logic [FRAC_W-1:0]  r_frac;
    logic [3:0]         r_sq_cnt;
    logic               r_neg;
    logic signed [LL_W-1:0] r_ll;
    logic               r_sat;
    logic               r_ovalid;
    logic [LL_W-1:0]    r_odata;
    logic               r_ouser;

    logic [31:0]      w_mul_a;
    logic [31:0]      w_mul_b;
    logic [MUL_W-1:0] w_prod;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    logic               w_in_acc;
    logic [1:0]         w_cmd;
    logic [1:0]         w_row;
    logic [1:0]         w_col;
    logic [PROB_W-1:0]  w_prob;
    logic               w_seq;
    logic [7:0]         w_gap;
    logic [2:0]         w_nclamp;
    logic [GAP_W-1:0]   w_reps;
    logic [SCALE_W-1:0] w_acc_sum;
    logic [19:0]        w_rnd;
    logic [PROB_W-1:0]  w_sat16;
    logic [SCALE_W-1:0] w_scale_sum;
    logic [31:0]        w_mnew;
    logic signed [7:0]  w_eoff;
    logic signed [23:0] w_l2;
    logic [21:0]        w_mag;
    logic [MUL_W-1:0]   w_lrnd;
    logic signed [LL_W:0] w_ln;
    logic signed [LL_W:0] w_t;
    logic [LL_W-1:0]    w_llsat;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd    = i_s_axis_tuser[1:0];
    assign w_seq    = i_s_axis_tuser[2];
    assign w_row    = i_s_axis_tdata[1:0];
    assign w_col    = i_s_axis_tdata[3:2];
    assign w_prob   = i_s_axis_tdata[19:4];
    assign w_gap    = i_s_axis_tdata[27:20];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    always_comb begin
        if (r_num_states < 3'd2) begin
            w_nclamp = 3'd2;
        end else if (32'(r_num_states) > MAX_STATES) begin
            w_nclamp = 3'(MAX_STATES);
        end else begin
            w_nclamp = r_num_states;
        end
        if (!r_gap_mode || w_gap < 8'd2) begin
            w_reps = GAP_W'(1);
        end else if (32'(w_gap) > MAX_GAP) begin
            w_reps = GAP_W'(MAX_GAP);
        end else begin
            w_reps = GAP_W'(w_gap);
        end
    end

    always_comb begin
        w_acc_sum   = r_acc + SCALE_W'(w_prod[PROD_W-1:0]);
        w_rnd       = 20'((w_acc_sum + SCALE_W'(16384)) >> 15);
        w_sat16     = (w_rnd > 20'd65535) ? 16'hFFFF : w_rnd[15:0];
        w_scale_sum = r_scale + SCALE_W'(w_prod[PROD_W-1:0]);
        w_mnew      = w_prod[61:30];
        w_eoff      = $signed({2'b00, r_exp}) - 8'sd27;
        w_l2        = (24'(w_eoff) <<< 16) + $signed({8'd0, r_frac});
        w_mag       = w_l2[23] ? 22'(-w_l2) : 22'(w_l2);
        w_lrnd      = w_prod + 64'h8000_0000;
        w_ln        = r_neg ? -$signed({11'd0, w_lrnd[53:32]})
                            : $signed({11'd0, w_lrnd[53:32]});
        w_t         = $signed({r_ll[LL_W-1], r_ll}) + w_ln;
        if (w_t[LL_W] != w_t[LL_W-1]) begin
            w_llsat = w_t[LL_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_llsat = w_t[LL_W-1:0];
        end
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_PMUL: begin
                w_mul_a = 32'(r_pred[r_idx]);
                w_mul_b = 32'(r_trans[r_idx][r_col]);
            end
            S_WMUL: begin
                w_mul_a = 32'(r_pred[r_idx]);
                w_mul_b = 32'(r_emit[r_idx]);
            end
            S_SMUL: begin
                w_mul_a = 32'(r_m);
                w_mul_b = 32'(r_m);
            end
            S_LMUL: begin
                w_mul_a = 32'(w_mag);
                w_mul_b = LN2_Q32;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_div_req.start = (r_state == S_DSTART);
        w_div_req.num   = (NUM_W'(r_u[r_idx]) << 15) + NUM_W'(r_scale >> 1);
        w_div_req.den   = r_scale;
    end

    hfl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    hfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= 3'd4;
            r_gap_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_NUM_STATES) begin
                r_num_states <= i_cfg_data;
            end else if (i_cfg_index == REG_GAP_MODE) begin
                r_gap_mode <= i_cfg_data[0];
            end
        end
    end

    // tables and working payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_cmd == CMD_LOAD_TRANS && 32'(w_row) < MAX_STATES
                && 32'(w_col) < MAX_STATES) begin
            r_trans[IDX_W'(w_row)][IDX_W'(w_col)] <= w_prob;
        end
        if (w_in_acc && w_cmd == CMD_LOAD_INIT && 32'(w_row) < MAX_STATES) begin
            r_init[IDX_W'(w_row)] <= w_prob;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_cmd == CMD_OBSERVE) begin
                    for (int k = 0; k < MAX_STATES; k++) begin
                        r_emit[k] <= i_s_axis_tdata[28 + 16*k +: 16];
                        r_pred[k] <= w_seq ? r_init[k] : r_fv[k];
                    end
                    r_last  <= IDX_W'(w_nclamp - 3'd1);
                    r_reps  <= w_reps;
                    r_acc   <= '0;
                    r_scale <= '0;
                end
            end
            S_PACC: begin
                if (r_idx == r_last) begin
                    r_nxt[r_col] <= w_sat16;
                    r_acc        <= '0;
                    if (r_col == r_last) begin
                        for (int k = 0; k < MAX_STATES; k++) begin
                            r_pred[k] <= (IDX_W'(k) == r_col) ? w_sat16 : r_nxt[k];
                        end
                        r_reps <= r_reps - 1'b1;
                    end
                end else begin
                    r_acc <= w_acc_sum;
                end
            end
            S_WACC: begin
                r_u[r_idx] <= w_prod[PROD_W-1:0];
                r_scale    <= w_scale_sum;
                r_norm     <= w_scale_sum;
                r_exp      <= EXP_W'(SCALE_W - 1);
            end
            S_NORM: begin
                if (r_norm[SCALE_W-1]) begin
                    r_m      <= r_norm[SCALE_W-1 -: MANT_W];
                    r_frac   <= '0;
                    r_sq_cnt <= '0;
                end else begin
                    r_norm <= r_norm << 1;
                    r_exp  <= r_exp - 1'b1;
                end
            end
            S_SSTEP: begin
                r_frac   <= {r_frac[FRAC_W-2:0], w_mnew[31]};
                r_m      <= w_mnew[31] ? w_mnew[31:1] : w_mnew[30:0];
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end
            S_LMUL: begin
                r_neg <= w_l2[23];
            end
            default: begin
            end
        endcase
    end

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_col    <= '0;
            r_ll     <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < MAX_STATES; k++) begin
                r_fv[k] <= '0;
            end
        end else begin
            if (r_ovalid && i_m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_col <= '0;
                    if (w_in_acc && w_cmd == CMD_OBSERVE) begin
                        r_state <= w_seq ? S_WMUL : S_PMUL;
                    end
                end
                S_PMUL: r_state <= S_PACC;
                S_PACC: begin
                    if (r_idx == r_last && r_col == r_last && r_reps == GAP_W'(1)) begin
                        r_state <= S_WMUL;
                    end else begin
                        r_state <= S_PMUL;
                    end
                    if (r_idx == r_last) begin
                        r_idx <= '0;
                        if (r_col == r_last) begin
                            r_col <= '0;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_WMUL: r_state <= S_WACC;
                S_WACC: begin
                    if (r_idx == r_last) begin
                        r_idx <= '0;
                        if (w_scale_sum == '0) begin
                            r_sat   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            for (int k = 0; k < MAX_STATES; k++) begin
                                if (IDX_W'(k) > r_last) begin
                                    r_fv[k] <= '0;
                                end
                            end
                            r_state <= S_DSTART;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_WMUL;
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_div_rsp.done) begin
                        r_fv[r_idx] <= w_div_rsp.quot;
                        if (r_idx == r_last) begin
                            r_state <= S_NORM;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_NORM: begin
                    if (r_norm[SCALE_W-1]) begin
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: r_state <= S_SSTEP;
                S_SSTEP: r_state <= (r_sq_cnt == 4'd15) ? S_LMUL : S_SMUL;
                S_LMUL: r_state <= S_LACC;
                S_LACC: begin
                    r_ll    <= $signed(w_llsat);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_sat ? 32'h8000_0000 : r_ll;
                        r_ouser  <= r_sat;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_flag_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 32'h8000_0000))
        else $error("underflow item without saturated total");
    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |=> r_sat)
        else $error("underflow latch cleared");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTART) |-> (r_scale != '0))
        else $error("division by zero scale");
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SMUL && $past(r_state) == S_NORM) |-> r_norm[SCALE_W-1])
        else $error("mantissa not normalized");
`endif

endmodule

FILE: tb/sv/hmm_loglik_checker.sv
`timescale 1ns / 1ps
module hmm_loglik_checker
    import hfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [95:0] i_s_data,
    input  logic [2:0]  i_s_user,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [31:0] i_m_data,
    input  logic        i_m_user,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] loglik;
        logic        underflow;
    } t_loglik_exp;

    t_loglik_exp loglik_expected[$];

    logic [15:0] trans_tab[4][4];
    logic [15:0] init_prob[4];
    logic [15:0] fwd_vec[4];
    logic signed [31:0] ll_total;
    logic        sticky_uf;
    logic [2:0]  cfg_states;
    logic        cfg_gap;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        o_fail_count++;
    endtask

    function automatic longint log2_fix(input logic [63:0] s);
        int e;
        logic [63:0] m;
        logic [15:0] fr;
        e = 63;
        fr = '0;
        while (e > 0 && !s[e]) e--;
        m = (e >= 30) ? (s >> (e - 30)) : (s << (30 - e));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            fr = {fr[14:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                fr[0] = 1'b1;
                m = m >> 1;
            end
        end
        return longint'(e - 27) * 65536 + longint'({48'd0, fr});
    endfunction

    function automatic longint ln_fix(input logic [63:0] s);
        longint l2;
        logic [63:0] mag;
        logic [63:0] r;
        l2 = log2_fix(s);
        mag = (l2 < 0) ? 64'(-l2) : 64'(l2);
        r = (mag * 64'd2977044472 + (64'd1 << 31)) >> 32;
        return (l2 < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic void predict_loglik(input logic [95:0] d, input logic seq_first);
        int n;
        int reps;
        logic [15:0] p[4];
        logic [15:0] nv[4];
        logic [63:0] u[4];
        logic [63:0] scale;
        logic [63:0] acc;
        logic [15:0] em;
        longint t;
        t_loglik_exp x;
        n = (cfg_states < 2) ? 2 : (cfg_states > 4) ? 4 : int'(cfg_states);
        scale = '0;
        if (seq_first) begin
            for (int m = 0; m < 4; m++) p[m] = init_prob[m];
        end else begin
            reps = 1;
            if (cfg_gap) begin
                reps = int'(d[27:20]);
                if (reps < 1) reps = 1;
                if (reps > DEF_MAX_GAP) reps = DEF_MAX_GAP;
            end
            for (int m = 0; m < 4; m++) p[m] = fwd_vec[m];
            for (int k = 0; k < reps; k++) begin
                for (int c = 0; c < n; c++) begin
                    acc = '0;
                    for (int r = 0; r < n; r++) acc += 64'(p[r]) * 64'(trans_tab[r][c]);
                    acc = (acc + 64'd16384) >> 15;
                    nv[c] = (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
                end
                for (int c = 0; c < n; c++) p[c] = nv[c];
            end
        end
        for (int m = 0; m < n; m++) begin
            em = d[28 + 16*m +: 16];
            u[m] = 64'(p[m]) * 64'(em);
            scale += u[m];
        end
        if (scale == 0) begin
            sticky_uf = 1'b1;
        end else begin
            for (int m = 0; m < 4; m++)
                fwd_vec[m] = (m < n) ? 16'(((u[m] << 15) + (scale >> 1)) / scale) : 16'd0;
            t = longint'(ll_total) + ln_fix(scale);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            ll_total = t[31:0];
        end
        x.loglik = sticky_uf ? 32'h8000_0000 : ll_total;
        x.underflow = sticky_uf;
        loglik_expected.push_back(x);
    endfunction

    always @(posedge i_clk) begin
        t_loglik_exp x;
        if (!i_rst_n) begin
            loglik_expected.delete();
            for (int m = 0; m < 4; m++) begin
                fwd_vec[m] = '0;
                init_prob[m] = '0;
                for (int c = 0; c < 4; c++) trans_tab[m][c] = '0;
            end
            ll_total = '0;
            sticky_uf = 1'b0;
            cfg_states = 3'd4;
            cfg_gap = 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_NUM_STATES) cfg_states = i_cfg_data;
                else if (i_cfg_index == REG_GAP_MODE) cfg_gap = i_cfg_data[0];
            end
            if (i_s_valid && i_s_ready) begin
                case (i_s_user[1:0])
                    CMD_LOAD_TRANS: trans_tab[i_s_data[1:0]][i_s_data[3:2]] = i_s_data[19:4];
                    CMD_LOAD_INIT:  init_prob[i_s_data[1:0]] = i_s_data[19:4];
                    CMD_OBSERVE:    predict_loglik(i_s_data, i_s_user[2]);
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) begin
                if (loglik_expected.size() == 0) begin
                    report("unexpected item", i_m_data, 32'd0);
                end else begin
                    x = loglik_expected.pop_front();
                    if (i_m_data !== x.loglik) report("log_likelihood", i_m_data, x.loglik);
                    if (i_m_user !== x.underflow)
                        report("underflow_flag", 32'(i_m_user), 32'(x.underflow));
                end
            end
        end
        o_pending = loglik_expected.size();
    end

endmodule

FILE: tb/sv/hmm_forward_loglik_unit_tb.sv
`timescale 1ns / 1ps
module hmm_forward_loglik_unit_tb;
    import hfl_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int IDLE_LIMIT = 100000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic [2:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [2:0]  i_cfg_data = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit want_hold = 0;
    bit no_gaps = 0;

    always #5 i_clk = ~i_clk;

    hmm_forward_loglik_unit DUT (.*);

    hmm_loglik_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .i_s_ready   (o_s_axis_tready),
        .i_s_data    (i_s_axis_tdata),
        .i_s_user    (i_s_axis_tuser),
        .i_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .i_m_data    (o_m_axis_tdata),
        .i_m_user    (o_m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int r;
        bit held;
        held = 0;
        forever begin
            @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (want_hold && !held) begin
                held = 1;
                i_m_axis_tready <= 1'b0;
                repeat (2500) @(posedge i_clk);
            end else if (r < 70) begin
                i_m_axis_tready <= 1'b1;
            end else if (r < 96) begin
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(20, 150)) @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [15:0] rand_emit();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [15:0] rand_prob();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 16'd32768;
        if (r == 1) return 16'd1;
        return 16'($urandom_range(1, 32768));
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [1:0] row, input logic [1:0] col,
                             input logic [15:0] prob, input logic seq_first,
                             input logic [7:0] gap, input logic [63:0] emits);
        int g;
        i_s_axis_tdata  <= {4'd0, emits, gap, prob, col, row};
        i_s_axis_tuser  <= {seq_first, cmd};
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        g = pick_gap();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_obs(input logic seq_first, input logic [7:0] gap,
                            input logic [63:0] emits);
        send_item(CMD_OBSERVE, 2'($urandom), 2'($urandom), 16'($urandom), seq_first, gap, emits);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_phase(input bit gap_on, input int items);
        int cnt;
        int r;
        logic [7:0] gap;
        cnt = 0;
        while (cnt < items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_item(CMD_NOP, 2'($urandom), 2'($urandom), 16'($urandom), 1'($urandom),
                          8'($urandom), {$urandom, $urandom});
            end else if (r < 16) begin
                send_item(CMD_LOAD_TRANS, 2'($urandom), 2'($urandom), rand_prob(), 1'($urandom),
                          8'($urandom), {$urandom, $urandom});
                cnt++;
            end else if (r < 20) begin
                send_item(CMD_LOAD_INIT, 2'($urandom), 2'($urandom), rand_prob(), 1'($urandom),
                          8'($urandom), {$urandom, $urandom});
                cnt++;
            end else begin
                r = $urandom_range(0, 99);
                if (!gap_on) gap = 8'($urandom);
                else if (r < 70) gap = 8'($urandom_range(0, 4));
                else if (r < 98) gap = 8'($urandom_range(5, 30));
                else gap = 8'($urandom_range(200, 255));
                send_obs($urandom_range(0, 9) == 0, gap,
                         {rand_emit(), rand_emit(), rand_emit(), rand_emit()});
                cnt++;
            end
        end
    endtask

    initial begin
        logic [15:0] tv;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // table and initial distribution, extremes mixed in
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                tv = (r == 0 && c == 1) ? 16'd0 : (r == 1 && c == 1) ? 16'd32768 : rand_prob();
                send_item(CMD_LOAD_TRANS, 2'(r), 2'(c), tv, 1'b0, 8'hFF, '1);
            end
            send_item(CMD_LOAD_INIT, 2'(r), 2'd0, (r == 0) ? 16'd32768 : rand_prob(),
                      1'b1, 8'd0, '0);
        end
        send_obs(1'b1, 8'd0, {4{16'hFFFF}});
        send_obs(1'b0, 8'hFF, {16'd0, 16'd0, 16'd1, 16'd1});
        send_item(CMD_NOP, 2'd3, 2'd3, 16'hFFFF, 1'b1, 8'hFF, '1);
        send_obs(1'b0, 8'd1, {16'hFFFF, 16'd0, 16'hFFFF, 16'd0});
        send_obs(1'b1, 8'd0, {16'd1, 16'd1, 16'd1, 16'd1});
        drain();

        write_reg(REG_NUM_STATES, 3'd2);
        want_hold = 1;
        no_gaps = 1;
        random_phase(1'b0, 160);
        no_gaps = 0;
        drain();
        write_reg(REG_GAP_MODE, 3'd1);
        write_reg(REG_NUM_STATES, 3'd4);
        random_phase(1'b1, 160);
        drain();
        write_reg(REG_NUM_STATES, 3'd3);
        write_reg(REG_GAP_MODE, 3'd6);
        random_phase(1'b0, 160);
        drain();
        write_reg(REG_GAP_MODE, 3'd7);
        write_reg(REG_NUM_STATES, 3'd0);
        random_phase(1'b1, 160);
        drain();
        write_reg(REG_NUM_STATES, 3'd7);
        no_gaps = 1;
        random_phase(1'b1, 160);
        no_gaps = 0;
        drain();
        write_reg(REG_GAP_MODE, 3'd0);
        write_reg(REG_NUM_STATES, 3'd1);
        random_phase(1'b0, 160);
        drain();
        write_reg(REG_NUM_STATES, 3'd5);
        random_phase(1'b0, 120);
        drain();

        // zero scale latches the underflow until reset
        send_obs(1'b1, 8'd0, '0);
        send_obs(1'b0, 8'd2, {4{16'd4096}});
        send_obs(1'b1, 8'd0, {4{16'hFFFF}});
        drain();
        repeat (200) @(posedge i_clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: hmm_forward_loglik_unit.f
rtl/hfl_pkg.sv
rtl/hfl_mul.sv
rtl/hfl_div.sv
rtl/hmm_forward_loglik_unit.sv
tb/sv/hmm_loglik_checker.sv
tb/sv/hmm_forward_loglik_unit_tb.sv
